>>> rtl/core_pattern_escape_to_native_assert.svh
// assertion macros for the checker file
`ifndef CORE_PATTERN_ESCAPE_TO_NATIVE_ASSERT_SVH
`define CORE_PATTERN_ESCAPE_TO_NATIVE_ASSERT_SVH

// same-cycle implication, clocked by clk, off during rst
`define CPEN_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpen check failed");

// next-cycle implication, clocked by clk, off during rst
`define CPEN_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpen check failed");

`endif

>>> rtl/cpen_pkg.sv
// ----------------------------------------------------------------------------
// cpen_pkg
// shared types, character codes and result expansion for the escape translator
// ----------------------------------------------------------------------------
package cpen_pkg;

  localparam int CmdqDepth = 4;
  localparam int CmdqAw    = 2;

  localparam logic [15:0] CapReset = 16'd1024;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChUpperE = 8'h45;
  localparam logic [7:0] ChLowerE = 8'h65;
  localparam logic [7:0] ChH      = 8'h68;
  localparam logic [7:0] ChN      = 8'h6e;
  localparam logic [7:0] ChD      = 8'h64;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChP      = 8'h70;
  localparam logic [7:0] ChG      = 8'h67;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChT      = 8'h74;

  // command codes from front to back
  typedef enum logic [3:0] {
    OP_PLAIN,      // copy byte
    OP_PLAIN_END,  // copy byte, then terminating nul
    OP_NUL,        // terminating nul only
    OP_ERROR,      // escape did not fit
    OP_ESC_BIG_E,  // %d%f
    OP_ESC_F,      // %f
    OP_ESC_N,      // %n
    OP_ESC_KEEP,   // % plus byte
    OP_ESC_LIT     // %% plus byte
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       status;
  } res_t;

  function automatic logic [2:0] res_count(op_t op);
    case (op)
      OP_PLAIN_END, OP_ESC_BIG_E: res_count = (op == OP_ESC_BIG_E) ? 3'd4 : 3'd2;
      OP_ESC_F, OP_ESC_N, OP_ESC_KEEP: res_count = 3'd2;
      OP_ESC_LIT: res_count = 3'd3;
      default: res_count = 3'd1;
    endcase
  endfunction

  function automatic res_t res_of(op_t op, logic [1:0] step, logic [7:0] x);
    res_t r;
    r = '{out_byte: ChPct, byte_valid: 1'b1, last: 1'b0, status: 1'b0};
    case (op)
      OP_PLAIN: r.out_byte = x;
      OP_PLAIN_END: begin
        if (step == 2'd0) begin
          r.out_byte = x;
        end else begin
          r.out_byte = ChNul;
          r.last     = 1'b1;
        end
      end
      OP_NUL: begin
        r.out_byte = ChNul;
        r.last     = 1'b1;
      end
      OP_ERROR: begin
        r.out_byte   = ChNul;
        r.byte_valid = 1'b0;
        r.last       = 1'b1;
        r.status     = 1'b1;
      end
      OP_ESC_BIG_E: begin
        case (step)
          2'd1:    r.out_byte = ChD;
          2'd3:    r.out_byte = ChF;
          default: r.out_byte = ChPct;
        endcase
      end
      OP_ESC_F: r.out_byte = (step == 2'd0) ? ChPct : ChF;
      OP_ESC_N: r.out_byte = (step == 2'd0) ? ChPct : ChN;
      OP_ESC_KEEP: r.out_byte = (step == 2'd0) ? ChPct : x;
      OP_ESC_LIT: r.out_byte = (step == 2'd2) ? x : ChPct;
      default: r = '{out_byte: ChNul, byte_valid: 1'b0, last: 1'b0, status: 1'b0};
    endcase
    return r;
  endfunction

endpackage

>>> rtl/cpen_front.sv
// ----------------------------------------------------------------------------
// cpen_front
// takes input bytes, tracks escape, count and drain state, issues commands
// ----------------------------------------------------------------------------
module cpen_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic [15:0]   out_capacity,
  output logic          cmd_push,
  output cpen_pkg::cmd_t cmd
);
  import cpen_pkg::*;

  logic        esc_pend, esc_pend_next;
  logic        draining, draining_next;
  logic [15:0] out_count, out_count_next;

  logic [15:0] lim;
  logic [17:0] j_ext, lim_ext;
  logic [2:0]  need;
  op_t         esc_op;
  logic        has_cmd;

  assign lim     = ((out_capacity == 16'd0) ? 16'd1 : out_capacity) - 16'd1;
  assign j_ext   = {2'b00, out_count};
  assign lim_ext = {2'b00, lim};

  always_comb begin
    case (in_byte)
      ChUpperE: begin
        need = 3'd4; esc_op = OP_ESC_BIG_E;
      end
      ChLowerE: begin
        need = 3'd2; esc_op = OP_ESC_F;
      end
      ChH: begin
        need = 3'd2; esc_op = OP_ESC_N;
      end
      ChP, ChG, ChU, ChT, ChPct: begin
        need = 3'd2; esc_op = OP_ESC_KEEP;
      end
      default: begin
        need = 3'd3; esc_op = OP_ESC_LIT;
      end
    endcase
  end

  always_comb begin
    esc_pend_next  = esc_pend;
    draining_next  = draining;
    out_count_next = out_count;
    has_cmd        = 1'b0;
    cmd            = '{op: OP_NUL, data: in_byte};
    if (draining) begin
      if (in_byte == ChNul) begin
        draining_next = 1'b0;
      end
    end else if (esc_pend) begin
      esc_pend_next = 1'b0;
      has_cmd       = 1'b1;
      if (in_byte == ChNul) begin
        out_count_next = 16'd0;
      end else if (j_ext + {15'd0, need} >= lim_ext) begin
        cmd.op         = OP_ERROR;
        out_count_next = 16'd0;
        draining_next  = 1'b1;
      end else begin
        cmd.op         = esc_op;
        out_count_next = out_count + {13'd0, need};
      end
    end else if (out_count >= lim) begin
      has_cmd        = 1'b1;
      out_count_next = 16'd0;
      draining_next  = (in_byte != ChNul);
    end else if (in_byte == ChNul) begin
      has_cmd        = 1'b1;
      out_count_next = 16'd0;
    end else if (in_byte == ChPct) begin
      esc_pend_next = 1'b1;
    end else begin
      has_cmd = 1'b1;
      if (j_ext + 18'd1 >= lim_ext) begin
        cmd.op         = OP_PLAIN_END;
        out_count_next = 16'd0;
        draining_next  = 1'b1;
      end else begin
        cmd.op         = OP_PLAIN;
        out_count_next = out_count + 16'd1;
      end
    end
  end

  assign cmd_push = accept && has_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_pend  <= 1'b0;
      draining  <= 1'b0;
      out_count <= 16'd0;
    end else if (accept) begin
      esc_pend  <= esc_pend_next;
      draining  <= draining_next;
      out_count <= out_count_next;
    end
  end

endmodule

>>> rtl/cpen_cmdq.sv
// ----------------------------------------------------------------------------
// cpen_cmdq
// small command queue between front and back
// ----------------------------------------------------------------------------
module cpen_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cpen_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output cpen_pkg::cmd_t dout,
  output logic           empty
);
  import cpen_pkg::*;

  cmd_t              mem [CmdqDepth];
  logic [CmdqAw-1:0] wr_ptr, rd_ptr;
  logic [CmdqAw:0]   count;
  logic              do_push, do_pop;

  assign full    = (count == (CmdqAw+1)'(CmdqDepth));
  assign empty   = (count == '0);
  assign dout    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + CmdqAw'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + CmdqAw'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (CmdqAw+1)'(1);
        2'b01:   count <= count - (CmdqAw+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/cpen_back.sv
// ----------------------------------------------------------------------------
// cpen_back
// expands commands into output register bytes, one per cycle unless pop stalls
// ----------------------------------------------------------------------------
module cpen_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_empty,
  input  cpen_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           pop,
  output logic           empty,
  output cpen_pkg::res_t res
);
  import cpen_pkg::*;

  logic [1:0] step, step_next;
  logic       out_valid;
  logic       load;
  logic       cmd_done;
  res_t       res_next;

  assign empty    = !out_valid;
  assign load     = (!out_valid || pop) && !cmd_empty;
  assign cmd_done = ({1'b0, step} + 3'd1) == res_count(cmd.op);
  assign cmd_pop  = load && cmd_done;
  assign res_next = res_of(cmd.op, step, cmd.data);

  always_comb begin
    step_next = step;
    if (load) begin
      step_next = cmd_done ? 2'd0 : step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 2'd0;
    end else begin
      step <= step_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

>>> rtl/core_pattern_escape_to_native.sv
// ----------------------------------------------------------------------------
// core_pattern_escape_to_native
// streaming translator of pattern escapes into native form, byte by byte
// ----------------------------------------------------------------------------
// usage:
//   input queue side: drive in_byte and raise push; a transfer happens on a
//   clock edge with push high and full low. byte 0 ends a pattern string.
//   result queue side: while empty is low the oldest result sits on out_byte,
//   byte_valid, last and status; a transfer happens with pop high.
//   cfg channel: cfg_data is the output capacity (nul included), written on
//   an edge with cfg_valid and cfg_ready high; only write it while idle.
// path: the command of an input byte is queued at its transfer, and its
//   first result is then loaded from the queue into the result register.
// throughput: the back end sends one result per cycle while pop keeps the
//   result register free; a byte makes 1 result when plain (2 when it
//   fills the buffer), up to 4 for an escape; a percent sign or a byte
//   skipped while draining makes none. the input side takes a byte every
//   cycle until the 4-entry command queue fills up.
// reset: clears escape, count and drain state, empties the queue and the
//   result register, and sets the capacity to 1024.
// stall: with pop low the result holds; the command queue fills and then
//   full holds the input side off.
// ----------------------------------------------------------------------------
module core_pattern_escape_to_native (
  input  logic        clk,
  input  logic        rst,
  // input byte queue
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic        status,
  // capacity register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import cpen_pkg::*;

  logic [15:0] out_capacity;
  logic        accept;
  logic        cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t        cmd_in, cmd_out;
  res_t        res;

  // capacity register, always ready for a transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CapReset;
    end else if (cfg_valid && cfg_ready) begin
      out_capacity <= cfg_data;
    end
  end

  // input side stalls only on a full command queue
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // front: escape / count / drain tracking, one byte per cycle while not full
  cpen_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .out_capacity (out_capacity),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  // decoupling queue between decode and expansion
  cpen_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  // back: one result byte per cycle into the output register, unless pop stalls
  cpen_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign out_byte   = res.out_byte;
  assign byte_valid = res.byte_valid;
  assign last       = res.last;
  assign status     = res.status;

endmodule

>>> rtl/cpen_checker.sv
// ----------------------------------------------------------------------------
// cpen_checker
// port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
`include "core_pattern_escape_to_native_assert.svh"

module cpen_checker (
  input logic       clk,
  input logic       rst,
  input logic       pop,
  input logic       empty,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       last,
  input logic       status
);

  // a waiting result holds until its transfer
  `CPEN_CHECK_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(last))

  // error result is a bare end marker
  `CPEN_CHECK(a_err_form, !empty && status, last && !byte_valid && out_byte == 8'h00)

  // every result other than the error one is written out
  `CPEN_CHECK(a_ok_written, !empty && !status, byte_valid)

  // a written final byte is the terminating nul
  `CPEN_CHECK(a_last_nul, !empty && last && byte_valid, out_byte == 8'h00 && !status)

endmodule

bind core_pattern_escape_to_native cpen_checker u_cpen_checker (
  .clk        (clk),
  .rst        (rst),
  .pop        (pop),
  .empty      (empty),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .last       (last),
  .status     (status)
);
